@@ src/stb_pkg.sv @@
// ----------------------------------------------------------------------------
// stb_pkg
// Shared widths, types and saturation helper for the sphere-to-box transform.
// ----------------------------------------------------------------------------
package stb_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int RAD_W      = 31;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int WIDE_W     = SUM_W + 1;
    localparam int ROOT_W     = DATA_W;
    localparam int RPROD_W    = RAD_W + ROOT_W;
    localparam int SQ_STAGES  = 16;
    localparam int SQ_STEPS   = ROOT_W / SQ_STAGES;
    localparam int REM_W      = ROOT_W + 2;
    localparam int TRY_W      = REM_W + 2;
    localparam int XF_STAGES  = 3;
    localparam int BOX_STAGES = 3;
    localparam int NUM_STAGES = 1 + XF_STAGES + SQ_STAGES + BOX_STAGES;
    localparam int ADDR_W     = 4;

    localparam logic [1:0] REG_CENTER_X = 2'd0;
    localparam logic [1:0] REG_CENTER_Y = 2'd1;
    localparam logic [1:0] REG_CENTER_Z = 2'd2;
    localparam logic [1:0] REG_RADIUS   = 2'd3;

    typedef logic signed [DATA_W-1:0] t_s32;
    typedef logic [RAD_W-1:0]         t_rad;
    typedef t_s32 [2:0]               t_vec3;
    typedef t_s32 [3:0]               t_row;
    typedef t_row [2:0]               t_mat;

    typedef struct packed {
        t_vec3 centre;
        t_rad  radius;
        t_vec3 box_min;
        t_vec3 box_max;
    } t_result;

    localparam t_rad RADIUS_RESET = t_rad'(1) << FRAC_BITS;

    function automatic t_s32 sat_s32(input logic signed [WIDE_W-1:0] v);
        logic [WIDE_W-DATA_W:0] top_bits;
        top_bits = v[WIDE_W-1:DATA_W-1];
        if ((&top_bits) || !(|top_bits)) begin
            sat_s32 = v[DATA_W-1:0];
        end else if (v[WIDE_W-1]) begin
            sat_s32 = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            sat_s32 = {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

endpackage

@@ src/stb_xform.sv @@
// ----------------------------------------------------------------------------
// stb_xform
// Three stages: products and squares, sums, then shift, translate and saturate.
// ----------------------------------------------------------------------------
module stb_xform (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  stb_pkg::t_mat                 i_mat,
    input  stb_pkg::t_s32                 i_cx,
    input  stb_pkg::t_s32                 i_cy,
    input  stb_pkg::t_s32                 i_cz,
    output stb_pkg::t_vec3                o_centre,
    output logic [stb_pkg::PROD_W-1:0]    o_sq
);
    import stb_pkg::*;

    t_s32                     w_cfg [3];
    logic [DATA_W-1:0]        w_abs [3];
    logic signed [PROD_W-1:0] n_prod [3][3];
    logic signed [PROD_W-1:0] r_prod [3][3];
    logic [PROD_W-1:0]        n_sqr [3];
    logic [PROD_W-1:0]        r_sqr [3];
    t_vec3                    r_t1;
    t_vec3                    r_t2;
    logic signed [SUM_W-1:0]  n_sum [3];
    logic signed [SUM_W-1:0]  r_sum [3];
    logic [PROD_W-1:0]        n_sumsq;
    logic [PROD_W-1:0]        r_sumsq;
    logic [PROD_W-1:0]        r_sq3;
    t_vec3                    n_cen;
    t_vec3                    r_cen;

    always_comb begin
        w_cfg[0] = i_cx;
        w_cfg[1] = i_cy;
        w_cfg[2] = i_cz;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_prod[i][j] = $signed(i_mat[i][j]) * $signed(w_cfg[j]);
            end
            w_abs[i] = i_mat[i][0][DATA_W-1] ? DATA_W'(-$signed(i_mat[i][0])) : i_mat[i][0];
            n_sqr[i] = w_abs[i] * w_abs[i];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_sum[i] = SUM_W'(r_prod[i][0]) + SUM_W'(r_prod[i][1]) + SUM_W'(r_prod[i][2]);
        end
        n_sumsq = r_sqr[0] + r_sqr[1] + r_sqr[2];
    end

    always_comb begin
        logic signed [SUM_W-1:0]  v_sh;
        logic signed [WIDE_W-1:0] v_wide;
        for (int i = 0; i < 3; i++) begin
            v_sh     = r_sum[i] >>> FRAC_BITS;
            v_wide   = WIDE_W'(v_sh) + WIDE_W'($signed(r_t2[i]));
            n_cen[i] = sat_s32(v_wide);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_prod[i][j] <= n_prod[i][j];
                end
                r_sqr[i] <= n_sqr[i];
                r_t1[i]  <= i_mat[i][3];
                r_sum[i] <= n_sum[i];
            end
            r_t2    <= r_t1;
            r_sumsq <= n_sumsq;
            r_sq3   <= r_sumsq;
            r_cen   <= n_cen;
        end
    end

    assign o_centre = r_cen;
    assign o_sq     = r_sq3;

endmodule

@@ src/stb_isqrt.sv @@
// ----------------------------------------------------------------------------
// stb_isqrt
// Pipelined integer square root, a fixed number of root bits per stage, with
// the centre carried alongside.
// ----------------------------------------------------------------------------
module stb_isqrt (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [stb_pkg::PROD_W-1:0]    i_sq,
    input  stb_pkg::t_vec3                i_centre,
    output logic [stb_pkg::ROOT_W-1:0]    o_root,
    output stb_pkg::t_vec3                o_centre
);
    import stb_pkg::*;

    logic [PROD_W-1:0] w_rad [SQ_STAGES];
    logic [REM_W-1:0]  w_rem [SQ_STAGES];
    logic [ROOT_W-1:0] w_q   [SQ_STAGES];
    t_vec3             w_cen [SQ_STAGES];
    logic [PROD_W-1:0] n_rad [SQ_STAGES];
    logic [REM_W-1:0]  n_rem [SQ_STAGES];
    logic [ROOT_W-1:0] n_q   [SQ_STAGES];
    logic [PROD_W-1:0] r_rad [SQ_STAGES];
    logic [REM_W-1:0]  r_rem [SQ_STAGES];
    logic [ROOT_W-1:0] r_q   [SQ_STAGES];
    t_vec3             r_cen [SQ_STAGES];

    always_comb begin
        w_rad[0] = i_sq;
        w_rem[0] = '0;
        w_q[0]   = '0;
        w_cen[0] = i_centre;
        for (int k = 1; k < SQ_STAGES; k++) begin
            w_rad[k] = r_rad[k-1];
            w_rem[k] = r_rem[k-1];
            w_q[k]   = r_q[k-1];
            w_cen[k] = r_cen[k-1];
        end
    end

    always_comb begin
        logic [PROD_W-1:0] v_rad;
        logic [REM_W-1:0]  v_rem;
        logic [ROOT_W-1:0] v_q;
        logic [TRY_W-1:0]  v_try;
        logic [TRY_W-1:0]  v_trial;
        for (int k = 0; k < SQ_STAGES; k++) begin
            v_rad = w_rad[k];
            v_rem = w_rem[k];
            v_q   = w_q[k];
            for (int s = 0; s < SQ_STEPS; s++) begin
                v_try   = {v_rem, v_rad[PROD_W-1 -: 2]};
                v_trial = {2'b00, v_q, 2'b01};
                if (v_try >= v_trial) begin
                    v_rem = REM_W'(v_try - v_trial);
                    v_q   = {v_q[ROOT_W-2:0], 1'b1};
                end else begin
                    v_rem = REM_W'(v_try);
                    v_q   = {v_q[ROOT_W-2:0], 1'b0};
                end
                v_rad = {v_rad[PROD_W-3:0], 2'b00};
            end
            n_rad[k] = v_rad;
            n_rem[k] = v_rem;
            n_q[k]   = v_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < SQ_STAGES; k++) begin
                r_rad[k] <= n_rad[k];
                r_rem[k] <= n_rem[k];
                r_q[k]   <= n_q[k];
                r_cen[k] <= w_cen[k];
            end
        end
    end

    assign o_root   = r_q[SQ_STAGES-1];
    assign o_centre = r_cen[SQ_STAGES-1];

endmodule

@@ src/stb_box.sv @@
// ----------------------------------------------------------------------------
// stb_box
// Radius scaling by the column length, radius saturation, and box corners.
// ----------------------------------------------------------------------------
module stb_box (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [stb_pkg::ROOT_W-1:0]    i_root,
    input  stb_pkg::t_vec3                i_centre,
    input  stb_pkg::t_rad                 i_radius,
    output stb_pkg::t_result              o_res
);
    import stb_pkg::*;

    logic [RPROD_W-1:0] n_rprod;
    logic [RPROD_W-1:0] r_rprod;
    t_vec3              r_c1;
    logic [RPROD_W-1:0] w_scaled;
    t_rad               n_rad;
    t_rad               r_rad2;
    t_vec3              r_c2;
    t_result            n_res;
    t_result            r_res;

    assign n_rprod  = i_radius * i_root;
    assign w_scaled = r_rprod >> FRAC_BITS;
    assign n_rad    = (|w_scaled[RPROD_W-1:RAD_W]) ? '1 : w_scaled[RAD_W-1:0];

    always_comb begin
        logic signed [WIDE_W-1:0] v_c;
        logic signed [WIDE_W-1:0] v_r;
        n_res.centre = r_c2;
        n_res.radius = r_rad2;
        v_r          = WIDE_W'(r_rad2);
        for (int i = 0; i < 3; i++) begin
            v_c              = WIDE_W'($signed(r_c2[i]));
            n_res.box_min[i] = sat_s32(v_c - v_r);
            n_res.box_max[i] = sat_s32(v_c + v_r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rprod <= n_rprod;
            r_c1    <= i_centre;
            r_rad2  <= n_rad;
            r_c2    <= r_c1;
            r_res   <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

@@ src/sphere_transform_to_box_core.sv @@
// ----------------------------------------------------------------------------
// sphere_transform_to_box_core
// Transforms a configured bounding sphere by one affine matrix per word and
// returns the new centre, radius and axis-aligned box.
//
//   Channel   Direction  Handshake                 Word
//   matrix    in         i_valid / o_stall         i_m00 .. i_m23
//   result    out        o_valid / i_stall         centre, radius, min, max
//   config    in         psel, penable, pwrite     centre X/Y/Z, radius
//
// One word is accepted per cycle while o_stall is low; the pipeline depth is
// set mostly by the 16-stage square root of the column length, two root bits
// per stage.
// Reset is synchronous and active low; it clears all valid bits, including
// those of the output and skid registers, and loads the register defaults.
// A stalled output catches one more word in a skid register; o_stall then
// rises and the whole pipeline holds until the result is taken.
// ----------------------------------------------------------------------------
module sphere_transform_to_box_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [stb_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  stb_pkg::t_s32                 i_m00,
    input  stb_pkg::t_s32                 i_m01,
    input  stb_pkg::t_s32                 i_m02,
    input  stb_pkg::t_s32                 i_m03,
    input  stb_pkg::t_s32                 i_m10,
    input  stb_pkg::t_s32                 i_m11,
    input  stb_pkg::t_s32                 i_m12,
    input  stb_pkg::t_s32                 i_m13,
    input  stb_pkg::t_s32                 i_m20,
    input  stb_pkg::t_s32                 i_m21,
    input  stb_pkg::t_s32                 i_m22,
    input  stb_pkg::t_s32                 i_m23,
    output logic                          o_valid,
    input  logic                          i_stall,
    output stb_pkg::t_s32                 o_out_center_x,
    output stb_pkg::t_s32                 o_out_center_y,
    output stb_pkg::t_s32                 o_out_center_z,
    output stb_pkg::t_rad                 o_out_radius,
    output stb_pkg::t_s32                 o_min_x,
    output stb_pkg::t_s32                 o_min_y,
    output stb_pkg::t_s32                 o_min_z,
    output stb_pkg::t_s32                 o_max_x,
    output stb_pkg::t_s32                 o_max_y,
    output stb_pkg::t_s32                 o_max_z
);
    import stb_pkg::*;

    t_s32                  r_cx;
    t_s32                  r_cy;
    t_s32                  r_cz;
    t_rad                  r_radius;
    logic                  w_cfg_wr;
    logic [1:0]            w_reg_idx;

    logic                  w_adv;
    logic [NUM_STAGES-1:0] r_valid;
    t_mat                  w_mat;
    t_mat                  r_mat;
    t_vec3                 w_xf_centre;
    logic [PROD_W-1:0]     w_xf_sq;
    logic [ROOT_W-1:0]     w_root;
    t_vec3                 w_sq_centre;
    t_result               w_res;

    t_result               r_out;
    logic                  r_out_v;
    t_result               r_skid;
    logic                  r_skid_v;
    logic                  w_take;
    logic                  w_last_v;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= '0;
            r_cy     <= '0;
            r_cz     <= '0;
            r_radius <= RADIUS_RESET;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_CENTER_X: r_cx     <= pwdata;
                REG_CENTER_Y: r_cy     <= pwdata;
                REG_CENTER_Z: r_cz     <= pwdata;
                REG_RADIUS:   r_radius <= pwdata[RAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_CENTER_X: prdata = r_cx;
            REG_CENTER_Y: prdata = r_cy;
            REG_CENTER_Z: prdata = r_cz;
            REG_RADIUS:   prdata = 32'(r_radius);
            default:      prdata = '0;
        endcase
    end

    assign w_adv   = !r_skid_v;
    assign o_stall = r_skid_v;

    always_comb begin
        w_mat[0][0] = i_m00;
        w_mat[0][1] = i_m01;
        w_mat[0][2] = i_m02;
        w_mat[0][3] = i_m03;
        w_mat[1][0] = i_m10;
        w_mat[1][1] = i_m11;
        w_mat[1][2] = i_m12;
        w_mat[1][3] = i_m13;
        w_mat[2][0] = i_m20;
        w_mat[2][1] = i_m21;
        w_mat[2][2] = i_m22;
        w_mat[2][3] = i_m23;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_adv) begin
            r_valid <= {r_valid[NUM_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_mat <= w_mat;
        end
    end

    stb_xform u_xform (
        .i_clk    (i_clk),
        .i_en     (w_adv),
        .i_mat    (r_mat),
        .i_cx     (r_cx),
        .i_cy     (r_cy),
        .i_cz     (r_cz),
        .o_centre (w_xf_centre),
        .o_sq     (w_xf_sq)
    );

    stb_isqrt u_isqrt (
        .i_clk    (i_clk),
        .i_en     (w_adv),
        .i_sq     (w_xf_sq),
        .i_centre (w_xf_centre),
        .o_root   (w_root),
        .o_centre (w_sq_centre)
    );

    stb_box u_box (
        .i_clk    (i_clk),
        .i_en     (w_adv),
        .i_root   (w_root),
        .i_centre (w_sq_centre),
        .i_radius (r_radius),
        .o_res    (w_res)
    );

    assign w_last_v = r_valid[NUM_STAGES-1];
    assign w_take   = r_out_v && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_take) begin
                r_skid_v <= 1'b0;
            end
        end else if (!r_out_v || w_take) begin
            r_out_v <= w_last_v;
        end else if (w_last_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (!r_out_v || w_take) begin
            if (w_last_v) begin
                r_out <= w_res;
            end
        end else if (w_last_v) begin
            r_skid <= w_res;
        end
    end

    assign o_valid        = r_out_v;
    assign o_out_center_x = r_out.centre[0];
    assign o_out_center_y = r_out.centre[1];
    assign o_out_center_z = r_out.centre[2];
    assign o_out_radius   = r_out.radius;
    assign o_min_x        = r_out.box_min[0];
    assign o_min_y        = r_out.box_min[1];
    assign o_min_z        = r_out.box_min[2];
    assign o_max_x        = r_out.box_max[0];
    assign o_max_y        = r_out.box_max[1];
    assign o_max_z        = r_out.box_max[2];

endmodule

@@ tb/sv/sphere_transform_to_box_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_transform_to_box_core_tb
// Drives affine matrices into the sphere-to-box transform under several
// sphere settings and random idling on both channels. Each accepted word is
// predicted from the current sphere registers, and every result word is
// compared field by field, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module sphere_transform_to_box_core_tb;
    import stb_pkg::*;

    localparam t_s32 S_MAX     = 32'sh7FFF_FFFF;
    localparam t_s32 S_MIN     = 32'sh8000_0000;
    localparam t_s32 ONE       = 32'sd65536;
    localparam t_rad R_MAX     = 31'h7FFF_FFFF;
    localparam int   PHASES    = 8;
    localparam int   PHASE_LEN = 235;
    localparam int   LONG_HOLD = 200;
    localparam int   SETTLE    = 40;

    typedef struct packed {
        t_mat    mat;
        logic    known;
        t_result want;
    } t_matrix_case;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 i_valid;
    logic                 o_stall;
    t_s32                 i_m00, i_m01, i_m02, i_m03;
    t_s32                 i_m10, i_m11, i_m12, i_m13;
    t_s32                 i_m20, i_m21, i_m22, i_m23;
    logic                 o_valid;
    logic                 i_stall;
    t_s32                 o_out_center_x, o_out_center_y, o_out_center_z;
    t_rad                 o_out_radius;
    t_s32                 o_min_x, o_min_y, o_min_z;
    t_s32                 o_max_x, o_max_y, o_max_z;

    t_s32                 cfg_cx, cfg_cy, cfg_cz;
    t_rad                 cfg_radius;
    t_result              pending_boxes [$];
    t_matrix_case         matrix_cases [$];
    int                   mismatches;
    bit                   src_idle;
    bit                   sink_idle;
    bit                   hold_req;

    sphere_transform_to_box_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_m00          (i_m00),
        .i_m01          (i_m01),
        .i_m02          (i_m02),
        .i_m03          (i_m03),
        .i_m10          (i_m10),
        .i_m11          (i_m11),
        .i_m12          (i_m12),
        .i_m13          (i_m13),
        .i_m20          (i_m20),
        .i_m21          (i_m21),
        .i_m22          (i_m22),
        .i_m23          (i_m23),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_center_x (o_out_center_x),
        .o_out_center_y (o_out_center_y),
        .o_out_center_z (o_out_center_z),
        .o_out_radius   (o_out_radius),
        .o_min_x        (o_min_x),
        .o_min_y        (o_min_y),
        .o_min_z        (o_min_z),
        .o_max_x        (o_max_x),
        .o_max_y        (o_max_y),
        .o_max_z        (o_max_z)
    );

    initial i_clk = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic signed [79:0] wide(input t_s32 v);
        wide = v;
    endfunction

    function automatic t_s32 clamp_s32(input logic signed [79:0] v);
        if (v > wide(S_MAX)) begin
            clamp_s32 = S_MAX;
        end else if (v < wide(S_MIN)) begin
            clamp_s32 = S_MIN;
        end else begin
            clamp_s32 = v[31:0];
        end
    endfunction

    // The centre sum is kept exact and floored; the column length is the
    // integer square root of the raw sum of squares.
    function automatic t_result predict_box(input t_mat m);
        t_result            res;
        logic signed [79:0] acc;
        logic signed [79:0] rad_w;
        logic [63:0]        col_sq;
        logic [63:0]        root;
        logic [63:0]        trial;
        logic [95:0]        scaled;
        int                 r;
        int                 b;
        for (r = 0; r < 3; r++) begin
            acc = wide(m[r][0]) * wide(cfg_cx) + wide(m[r][1]) * wide(cfg_cy)
                + wide(m[r][2]) * wide(cfg_cz) + (wide(m[r][3]) <<< FRAC_BITS);
            res.centre[r] = clamp_s32(acc >>> FRAC_BITS);
        end
        acc = wide(m[0][0]) * wide(m[0][0]) + wide(m[1][0]) * wide(m[1][0])
            + wide(m[2][0]) * wide(m[2][0]);
        col_sq = acc[63:0];
        root = '0;
        for (b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= col_sq) begin
                root = trial;
            end
        end
        scaled = (96'(cfg_radius) * 96'(root)) >> FRAC_BITS;
        res.radius = (scaled > 96'(R_MAX)) ? R_MAX : scaled[RAD_W-1:0];
        rad_w = {49'd0, res.radius};
        for (r = 0; r < 3; r++) begin
            res.box_min[r] = clamp_s32(wide(res.centre[r]) - rad_w);
            res.box_max[r] = clamp_s32(wide(res.centre[r]) + rad_w);
        end
        return res;
    endfunction

    function automatic t_mat mk_mat(input t_s32 a00, a01, a02, a03, a10, a11, a12, a13,
                                    input t_s32 a20, a21, a22, a23);
        t_mat m;
        m[0][0] = a00; m[0][1] = a01; m[0][2] = a02; m[0][3] = a03;
        m[1][0] = a10; m[1][1] = a11; m[1][2] = a12; m[1][3] = a13;
        m[2][0] = a20; m[2][1] = a21; m[2][2] = a22; m[2][3] = a23;
        return m;
    endfunction

    function automatic t_result mk_res(input t_s32 cx, cy, cz, input t_rad r,
                                       input t_s32 lx, ly, lz, hx, hy, hz);
        t_result res;
        res.centre[0]  = cx; res.centre[1]  = cy; res.centre[2]  = cz;
        res.radius     = r;
        res.box_min[0] = lx; res.box_min[1] = ly; res.box_min[2] = lz;
        res.box_max[0] = hx; res.box_max[1] = hy; res.box_max[2] = hz;
        return res;
    endfunction

    function automatic t_s32 rand_elem();
        case ($urandom_range(0, 3))
            0: rand_elem = $urandom;
            1: rand_elem = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            2: rand_elem = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
            default: begin
                case ($urandom_range(0, 3))
                    0: rand_elem = S_MAX;
                    1: rand_elem = S_MIN;
                    2: rand_elem = ONE;
                    default: rand_elem = -ONE;
                endcase
            end
        endcase
    endfunction

    function automatic t_mat rand_mat();
        t_mat m;
        int   r;
        int   c;
        for (r = 0; r < 3; r++) begin
            for (c = 0; c < 4; c++) begin
                m[r][c] = rand_elem();
            end
        end
        return m;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic add_case(input t_mat m, input logic known, input t_result want);
        t_matrix_case row;
        row.mat   = m;
        row.known = known;
        row.want  = want;
        matrix_cases.push_back(row);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] want;
        case (idx)
            REG_CENTER_X: cfg_cx = value;
            REG_CENTER_Y: cfg_cy = value;
            REG_CENTER_Z: cfg_cz = value;
            REG_RADIUS:   cfg_radius = value[RAD_W-1:0];
            default: ;
        endcase
        want = (idx == REG_RADIUS) ? {1'b0, cfg_radius} : value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        check_field("prdata", want, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_sphere(input logic [31:0] cx, cy, cz, r);
        reg_write(REG_CENTER_X, cx);
        reg_write(REG_CENTER_Y, cy);
        reg_write(REG_CENTER_Z, cz);
        reg_write(REG_RADIUS, r);
    endtask

    task automatic send_mat(input t_mat m, input logic known, input t_result want);
        int unsigned gap;
        gap = src_idle ? $urandom_range(0, 5) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_m00 <= m[0][0]; i_m01 <= m[0][1]; i_m02 <= m[0][2]; i_m03 <= m[0][3];
        i_m10 <= m[1][0]; i_m11 <= m[1][1]; i_m12 <= m[1][2]; i_m13 <= m[1][3];
        i_m20 <= m[2][0]; i_m21 <= m[2][1]; i_m22 <= m[2][2]; i_m23 <= m[2][3];
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_boxes.push_back(known ? want : predict_box(m));
    endtask

    task automatic settle();
        while (pending_boxes.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // While sink_idle is set, each result word is preceded by a random stall;
    // one long hold-off on request lets the pipeline fill and back-pressure.
    initial begin : result_sink
        int unsigned hold;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            hold = sink_idle ? $urandom_range(0, 5) : 0;
            if (hold != 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_boxes.size() == 0) begin
                $error("result word with no prediction pending");
                mismatches++;
            end else begin
                want = pending_boxes.pop_front();
                check_field("out_center_x", want.centre[0], o_out_center_x);
                check_field("out_center_y", want.centre[1], o_out_center_y);
                check_field("out_center_z", want.centre[2], o_out_center_z);
                check_field("out_radius", {1'b0, want.radius}, {1'b0, o_out_radius});
                check_field("min_x", want.box_min[0], o_min_x);
                check_field("min_y", want.box_min[1], o_min_y);
                check_field("min_z", want.box_min[2], o_min_z);
                check_field("max_x", want.box_max[0], o_max_x);
                check_field("max_y", want.box_max[1], o_max_y);
                check_field("max_z", want.box_max[2], o_max_z);
            end
        end
    end

    initial begin : stimulus
        int           pass;
        int           ph;
        int           k;
        t_matrix_case row;
        i_rst_n    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        i_valid    = 1'b0;
        i_stall    = 1'b0;
        {i_m00, i_m01, i_m02, i_m03} = '0;
        {i_m10, i_m11, i_m12, i_m13} = '0;
        {i_m20, i_m21, i_m22, i_m23} = '0;
        cfg_cx     = '0;
        cfg_cy     = '0;
        cfg_cz     = '0;
        cfg_radius = RADIUS_RESET;
        mismatches = 0;
        src_idle   = 1'b1;
        sink_idle  = 1'b1;
        hold_req   = 1'b0;

        // With the reset sphere the centre equals the translation and the
        // radius equals the integer root of the first column's squares.
        add_case(mk_mat(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                 mk_res(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_case(mk_mat(ONE, 0, 0, 0, 0, ONE, 0, 0, 0, 0, ONE, 0), 1'b1,
                 mk_res(0, 0, 0, 31'h0001_0000, -ONE, -ONE, -ONE, ONE, ONE, ONE));
        add_case(mk_mat(ONE, 0, 0, S_MAX, 0, ONE, 0, S_MIN, 0, 0, ONE, -1), 1'b1,
                 mk_res(S_MAX, S_MIN, -1, 31'h0001_0000, 32'h7FFE_FFFF, S_MIN,
                        32'hFFFE_FFFF, S_MAX, 32'h8001_0000, 32'h0000_FFFF));
        add_case(mk_mat(S_MIN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                 mk_res(0, 0, 0, R_MAX, 32'h8000_0001, 32'h8000_0001, 32'h8000_0001,
                        S_MAX, S_MAX, S_MAX));
        add_case(mk_mat(S_MIN, 0, 0, 0, S_MIN, 0, 0, 0, S_MIN, 0, 0, 0), 1'b1,
                 mk_res(0, 0, 0, R_MAX, 32'h8000_0001, 32'h8000_0001, 32'h8000_0001,
                        S_MAX, S_MAX, S_MAX));
        add_case(mk_mat(S_MAX, 0, 0, S_MIN, 0, 0, 0, S_MIN, 0, 0, 0, S_MIN), 1'b1,
                 mk_res(S_MIN, S_MIN, S_MIN, R_MAX, S_MIN, S_MIN, S_MIN, -1, -1, -1));
        add_case(mk_mat(0, 0, 0, 0, 3, 0, 0, 0, 4, 0, 0, 0), 1'b1,
                 mk_res(0, 0, 0, 31'd5, -5, -5, -5, 5, 5, 5));
        add_case(mk_mat(1, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                 mk_res(0, 0, 0, 31'd1, -1, -1, -1, 1, 1, 1));
        add_case(mk_mat(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX,
                        S_MAX, S_MAX, S_MAX, S_MAX), 1'b1,
                 mk_res(S_MAX, S_MAX, S_MAX, R_MAX, 0, 0, 0, S_MAX, S_MAX, S_MAX));
        add_case(mk_mat(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN,
                        S_MIN, S_MIN, S_MIN, S_MIN), 1'b1,
                 mk_res(S_MIN, S_MIN, S_MIN, R_MAX, S_MIN, S_MIN, S_MIN, -1, -1, -1));
        add_case(mk_mat(1, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1, 0), 1'b1,
                 mk_res(0, 0, 0, 31'd1, -1, -1, -1, 1, 1, 1));
        add_case(mk_mat(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1), 1'b1,
                 mk_res(-1, -1, -1, 31'd1, -2, -2, -2, 0, 0, 0));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The second walk of the table uses an off-grid sphere so that the
        // centre floors towards minus infinity and saturates both ways.
        for (pass = 0; pass < 2; pass++) begin
            if (pass == 1) begin
                load_sphere(32'hFFFF_FFFF, S_MAX, S_MIN, 32'h0003_0001);
            end
            for (k = 0; k < matrix_cases.size(); k++) begin
                row = matrix_cases[k];
                send_mat(row.mat, row.known && (pass == 0), row.want);
            end
            i_valid <= 1'b0;
            settle();
        end

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: load_sphere(3 * ONE, -2 * ONE, 32'h0000_8000, 2 * ONE);
                1: load_sphere(S_MAX, S_MIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                2: load_sphere(0, 0, 0, 0);
                4: load_sphere($urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000,
                               $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000,
                               $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000,
                               $urandom_range(0, 32'h0004_0000));
                5: load_sphere(S_MIN, S_MIN, S_MIN, 1);
                7: load_sphere(S_MAX, S_MAX, S_MAX, 32'h4000_0000);
                default: load_sphere($urandom, $urandom, $urandom, $urandom);
            endcase
            src_idle  = (ph != 1) && (ph != 4);
            sink_idle = (ph != 1) && (ph != 2);
            if (ph == 4) begin
                hold_req = 1'b1;
            end
            for (k = 0; k < PHASE_LEN; k++) begin
                send_mat(rand_mat(), 1'b0, '0);
            end
            i_valid <= 1'b0;
            settle();
        end

        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ sim.f @@
src/stb_pkg.sv
src/stb_xform.sv
src/stb_isqrt.sv
src/stb_box.sv
src/sphere_transform_to_box_core.sv
tb/sv/sphere_transform_to_box_core_tb.sv
